FILE: hdl/mnct_pkg.sv
package mnct_pkg;

	localparam int DATA_W     = 7;
	localparam int NOTE_NUM   = 128;
	localparam int COUNT_W    = 8;
	localparam int BEND_W     = 14;
	localparam int KIND_W     = 3;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 176;

	localparam logic [BEND_W-1:0] BEND_CENTRE = 14'd8192;

	typedef enum logic [KIND_W-1:0] {
		KIND_NOTE_ON,
		KIND_NOTE_OFF,
		KIND_CONTROL,
		KIND_BEND,
		KIND_PROGRAM,
		KIND_AFTERTOUCH,
		KIND_PRESSURE,
		KIND_OTHER
	} kind_t;

	typedef struct packed {
		logic              vel_we;
		logic              ctrl_we;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic [DATA_W-1:0] vel;
		logic [DATA_W-1:0] ctrl;
	} store_rd_t;

endpackage

FILE: hdl/mnct_store.sv
module mnct_store
	import mnct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  store_wr_t         wr,
	input  logic              rd_en,
	input  logic [DATA_W-1:0] rd_addr,
	output store_rd_t         rd
);

	logic [DATA_W-1:0] vel_mem  [NOTE_NUM];
	logic [DATA_W-1:0] ctrl_mem [NOTE_NUM];
	logic [NOTE_NUM-1:0] ctrl_valid_q;

	logic [DATA_W-1:0] vel_rd_q;
	logic [DATA_W-1:0] ctrl_rd_q;
	logic [DATA_W-1:0] byp_q;
	logic              ctrl_ok_q;
	logic              vel_hit_q;
	logic              ctrl_hit_q;

	always_ff @(posedge clk) begin
		if (wr.vel_we) begin
			vel_mem[wr.addr] <= wr.data;
		end
		if (wr.ctrl_we) begin
			ctrl_mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			vel_rd_q  <= vel_mem[rd_addr];
			ctrl_rd_q <= ctrl_mem[rd_addr];
			byp_q     <= wr.data;
		end
	end

	// forward a write that lands on the edge of the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_valid_q <= '0;
			ctrl_ok_q    <= 1'b0;
			vel_hit_q    <= 1'b0;
			ctrl_hit_q   <= 1'b0;
		end else begin
			if (wr.ctrl_we) begin
				ctrl_valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				ctrl_ok_q  <= ctrl_valid_q[rd_addr];
				vel_hit_q  <= wr.vel_we && (wr.addr == rd_addr);
				ctrl_hit_q <= wr.ctrl_we && (wr.addr == rd_addr);
			end
		end
	end

	always_comb begin
		rd.vel  = vel_hit_q ? byp_q : vel_rd_q;
		rd.ctrl = ctrl_hit_q ? byp_q : (ctrl_ok_q ? ctrl_rd_q : '0);
	end

endmodule

FILE: hdl/midi_note_and_controller_tracker_top.sv
// channel  beat fields (lowest bit first)
// s_axis   tdata: first_data[6:0], second_data[13:7], zero[15:14]; tuser: kind[2:0]
// m_axis   tdata: active_low, active_high, active_count, bend_value, program_now,
//                 note_velocity, controller_value, zero[175:171]
//
// One beat per cycle sustained while m_axis_tready is high; a result leaves after its input beat
// passes through the input register and then the result register.
// The store read is issued on the input beat and a write on the same edge is forwarded.
// arst_n clears held notes, count, program, controller values; bend goes to centre.
// A stalled result holds the input stage, which then holds s_axis_tready low.
module midi_note_and_controller_tracker_top
	import mnct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // first_data, second_data, pad
	input  logic [KIND_W-1:0]     s_axis_tuser,  // kind
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // active_low .. controller_value, pad
);

	logic              valid_s1;
	kind_t             kind_s1;
	logic [DATA_W-1:0] d1_s1;
	logic [DATA_W-1:0] d2_s1;

	logic [NOTE_NUM-1:0] bitmap_q;
	logic [COUNT_W-1:0]  count_q;
	logic [BEND_W-1:0]   bend_q;
	logic [DATA_W-1:0]   program_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic in_beat;
	logic adv;

	store_wr_t wr;
	store_rd_t rd;

	logic                held;
	logic                press;
	logic                release_note;
	logic [NOTE_NUM-1:0] bitmap_nx;
	logic [COUNT_W-1:0]  count_nx;
	logic [BEND_W-1:0]   bend_nx;
	logic [DATA_W-1:0]   program_nx;
	logic [DATA_W-1:0]   vel_out;
	logic [DATA_W-1:0]   ctrl_out;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		held         = bitmap_q[d1_s1];
		press        = 1'b0;
		release_note = 1'b0;
		bend_nx      = bend_q;
		program_nx   = program_q;
		case (kind_s1)
			KIND_NOTE_ON: begin
				press        = (d2_s1 != '0);
				release_note = (d2_s1 == '0);
			end
			KIND_NOTE_OFF: begin
				release_note = 1'b1;
			end
			KIND_BEND: begin
				bend_nx = {d2_s1, d1_s1};
			end
			KIND_PROGRAM: begin
				program_nx = d1_s1;
			end
			default: begin
			end
		endcase

		bitmap_nx = bitmap_q;
		count_nx  = count_q;
		if (press && !held) begin
			bitmap_nx[d1_s1] = 1'b1;
			count_nx         = count_q + 1'b1;
		end
		if (release_note && held) begin
			bitmap_nx[d1_s1] = 1'b0;
			count_nx         = count_q - 1'b1;
		end

		if (press) begin
			vel_out = d2_s1;
		end else if (bitmap_nx[d1_s1]) begin
			vel_out = rd.vel;
		end else begin
			vel_out = '0;
		end
		ctrl_out = (kind_s1 == KIND_CONTROL) ? d2_s1 : rd.ctrl;

		wr.vel_we  = adv && press;
		wr.ctrl_we = adv && (kind_s1 == KIND_CONTROL);
		wr.addr    = d1_s1;
		wr.data    = d2_s1;
	end

	mnct_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (in_beat),
		.rd_addr (s_axis_tdata[DATA_W-1:0]),
		.rd      (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			bitmap_q    <= '0;
			count_q     <= '0;
			bend_q      <= BEND_CENTRE;
			program_q   <= '0;
		end else begin
			if (in_beat) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				bitmap_q    <= bitmap_nx;
				count_q     <= count_nx;
				bend_q      <= bend_nx;
				program_q   <= program_nx;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_s1 <= kind_t'(s_axis_tuser);
			d1_s1   <= s_axis_tdata[DATA_W-1:0];
			d2_s1   <= s_axis_tdata[2*DATA_W-1:DATA_W];
		end
		if (adv) begin
			out_data_q <= {5'b0, ctrl_out, vel_out, program_nx, bend_nx, count_nx, bitmap_nx};
		end
	end

endmodule

FILE: bench/midi_note_and_controller_tracker_top_tb.sv
`timescale 1ns / 1ps

module midi_note_and_controller_tracker_top_tb;
	import mnct_pkg::*;

	typedef struct packed {
		logic [4:0]         pad;
		logic [DATA_W-1:0]  controller_value;
		logic [DATA_W-1:0]  note_velocity;
		logic [DATA_W-1:0]  program_now;
		logic [BEND_W-1:0]  bend_value;
		logic [COUNT_W-1:0] active_count;
		logic [63:0]        active_high;
		logic [63:0]        active_low;
	} tracker_out_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic [NOTE_NUM-1:0] held_map = '0;
	logic [DATA_W-1:0]   vel_mem [NOTE_NUM];
	logic [DATA_W-1:0]   ctrl_mem [NOTE_NUM];
	logic [COUNT_W-1:0]  held_total = '0;
	logic [BEND_W-1:0]   bend_reg = BEND_CENTRE;
	logic [DATA_W-1:0]   prog_reg = '0;

	tracker_out_t pending_results [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int fail_count = 0;
	int events_sent = 0;
	int results_checked = 0;
	int peak_held = 0;

	midi_note_and_controller_tracker_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	function automatic void release_note(logic [DATA_W-1:0] n);
		if (held_map[n]) begin
			held_map[n] = 1'b0;
			held_total--;
		end
	endfunction

	function automatic tracker_out_t track_event(kind_t k, logic [DATA_W-1:0] n,
			logic [DATA_W-1:0] v);
		tracker_out_t r;
		r = '0;
		case (k)
			KIND_NOTE_ON: begin
				if (v != 0) begin
					if (!held_map[n]) begin
						held_map[n] = 1'b1;
						held_total++;
					end
					vel_mem[n] = v;
				end else begin
					release_note(n);
				end
			end
			KIND_NOTE_OFF: release_note(n);
			KIND_CONTROL: ctrl_mem[n] = v;
			KIND_BEND: bend_reg = {v, n};
			KIND_PROGRAM: prog_reg = n;
			default: ;
		endcase
		if (held_total > peak_held)
			peak_held = held_total;
		r.active_low       = held_map[63:0];
		r.active_high      = held_map[127:64];
		r.active_count     = held_total;
		r.bend_value       = bend_reg;
		r.program_now      = prog_reg;
		r.note_velocity    = held_map[n] ? vel_mem[n] : '0;
		r.controller_value = ctrl_mem[n];
		return r;
	endfunction

	task automatic send_event(kind_t k, logic [DATA_W-1:0] d1, logic [DATA_W-1:0] d2);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, d2, d1};
		s_axis_tuser  <= k;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		pending_results.insert(pending_results.size(), track_event(k, d1, d2));
		events_sent++;
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		tracker_out_t got;
		tracker_out_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = tracker_out_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("active_low", want.active_low, got.active_low);
				check_field("active_high", want.active_high, got.active_high);
				check_field("active_count", 64'(want.active_count),
					64'(got.active_count));
				check_field("bend_value", 64'(want.bend_value), 64'(got.bend_value));
				check_field("program_now", 64'(want.program_now),
					64'(got.program_now));
				check_field("note_velocity", 64'(want.note_velocity),
					64'(got.note_velocity));
				check_field("controller_value", 64'(want.controller_value),
					64'(got.controller_value));
				results_checked++;
			end
		end
	end

	task automatic test_directed();
		send_event(KIND_AFTERTOUCH, 7'd5, 7'd5);
		send_event(KIND_NOTE_ON, 7'd0, 7'd127);
		send_event(KIND_NOTE_ON, 7'd127, 7'd1);
		send_event(KIND_NOTE_ON, 7'd0, 7'd5);
		send_event(KIND_NOTE_OFF, 7'd127, 7'd64);
		send_event(KIND_NOTE_OFF, 7'd127, 7'd0);
		send_event(KIND_NOTE_ON, 7'd64, 7'd0);
		send_event(KIND_NOTE_ON, 7'd63, 7'd127);
		send_event(KIND_NOTE_ON, 7'd64, 7'd42);
		send_event(KIND_NOTE_ON, 7'd63, 7'd0);
		send_event(KIND_CONTROL, 7'd0, 7'd127);
		send_event(KIND_CONTROL, 7'd127, 7'd1);
		send_event(KIND_PRESSURE, 7'd127, 7'd0);
		send_event(KIND_CONTROL, 7'd127, 7'd0);
		send_event(KIND_BEND, 7'd0, 7'd0);
		send_event(KIND_BEND, 7'd127, 7'd127);
		send_event(KIND_BEND, 7'd0, 7'd64);
		send_event(KIND_PROGRAM, 7'd127, 7'd127);
		send_event(KIND_PROGRAM, 7'd0, 7'd85);
		send_event(KIND_AFTERTOUCH, 7'd0, 7'd127);
		send_event(KIND_PRESSURE, 7'd64, 7'd127);
		send_event(KIND_OTHER, 7'd127, 7'd127);
		send_event(KIND_OTHER, 7'd0, 7'd0);
		send_event(KIND_NOTE_OFF, 7'd0, 7'd127);
		send_event(KIND_NOTE_OFF, 7'd64, 7'd0);
	endtask

	task automatic test_full_keyboard();
		logic [DATA_W-1:0] order [NOTE_NUM];
		logic [DATA_W-1:0] t;
		int j;
		for (int i = 0; i < NOTE_NUM; i++)
			order[i] = i[DATA_W-1:0];
		for (int i = NOTE_NUM - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[i]) begin
			send_event(KIND_NOTE_ON, order[i], 7'($urandom_range(127, 1)));
			if (i % 16 == 15)
				send_event(KIND_PRESSURE, 7'($urandom_range(127)),
					7'($urandom_range(127)));
		end
		send_event(KIND_NOTE_ON, order[5], 7'($urandom_range(127, 1)));
		for (int i = NOTE_NUM - 1; i >= 0; i--) begin
			if (i[0])
				send_event(KIND_NOTE_OFF, order[i], 7'($urandom_range(127)));
			else
				send_event(KIND_NOTE_ON, order[i], 7'd0);
		end
	endtask

	task automatic test_random(int count);
		int roll;
		int pool_base;
		logic [DATA_W-1:0] n;
		pool_base = $urandom_range(112);
		for (int i = 0; i < count; i++) begin
			n = ($urandom_range(99) < 70) ? 7'(pool_base + $urandom_range(15))
				: 7'($urandom_range(127));
			roll = $urandom_range(99);
			if (roll < 35)
				send_event(KIND_NOTE_ON, n,
					($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1)));
			else if (roll < 55)
				send_event(KIND_NOTE_OFF, n, 7'($urandom_range(127)));
			else if (roll < 68)
				send_event(KIND_CONTROL, 7'($urandom_range(127)),
					7'($urandom_range(127)));
			else if (roll < 72)
				send_event(KIND_CONTROL, n, 7'($urandom_range(127)));
			else if (roll < 80)
				send_event(KIND_BEND, 7'($urandom_range(127)), 7'($urandom_range(127)));
			else if (roll < 86)
				send_event(KIND_PROGRAM, 7'($urandom_range(127)),
					7'($urandom_range(127)));
			else
				send_event(kind_t'($urandom_range(7, 5)), n, 7'($urandom_range(127)));
		end
	endtask

	task automatic test_backpressure();
		hold_req = 300;
		for (int i = 0; i < 40; i++)
			send_event(kind_t'($urandom_range(7)), 7'($urandom_range(127)),
				7'($urandom_range(127)));
	endtask

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		for (int i = 0; i < NOTE_NUM; i++)
			ctrl_mem[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 13;
		rx_idle_pct = 65;
		test_directed();
		test_full_keyboard();
		test_random(330);

		tx_idle_pct = 65;
		rx_idle_pct = 13;
		test_random(330);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(330);
		test_backpressure();
		test_random(100);

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d events, %0d results checked, up to %0d notes held at once",
			events_sent, results_checked, peak_held);
		$display("all kinds, full keyboard, bend and controller extremes, long output stall");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
hdl/mnct_pkg.sv
hdl/mnct_store.sv
hdl/midi_note_and_controller_tracker_top.sv
bench/midi_note_and_controller_tracker_top_tb.sv
